### sv/xmrx_pkg.sv
// Shared types, character codes and CRC helper for the XMODEM-1K receiver.
package xmrx_pkg;

  // Serial character codes
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  // Input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam int         CFG_INDEX_W         = 1;
  localparam logic [0:0] CFG_MAX_ERRORS      = 1'd0;
  localparam logic [0:0] CFG_IDLE_EXIT_LIMIT = 1'd1;

  // Payload lengths and CRC polynomial
  localparam int          INDEX_W       = 11;
  localparam logic [10:0] SOH_PAYLOAD   = 11'd128;
  localparam logic [10:0] STX_PAYLOAD   = 11'd1024;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [7:0]  BLOCK_SUM     = 8'hFF;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BLOCK,
    PH_CHECK,
    PH_DATA,
    PH_CRCHI,
    PH_CRCLO
  } phase_t;

  typedef enum logic [1:0] {
    SS_RUN   = 2'd0,
    SS_DONE  = 2'd1,
    SS_ABORT = 2'd2
  } sess_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       verdict_valid;
    logic       packet_good;
    logic       crc_error;
    logic       number_error;
    logic [1:0] session_status;
    logic       last;
  } out_t;

  // CRC-16/XMODEM update over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### sv/xmodem_1k_crc_receiver_unit.sv
// XMODEM-1K CRC-mode receiver: deframing, checking, replies and a small result queue.
//
// One input item (start, received byte or timeout tick) is taken per clock cycle
// while in_ready is high. Its results, zero, one or two, are computed in the
// transfer cycle and land in a registered four-entry result queue. The output
// drains one result per cycle while out_ready is high, so in_ready drops only while
// fewer than two queue slots are free (an item can produce CAN CAN). The CRC update
// is one byte per cycle while in_ready is high. Configuration writes apply at once.
module xmodem_1k_crc_receiver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  xmrx_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output xmrx_pkg::out_t                      out_data,
  input  logic                                cfg_write,
  input  logic [xmrx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                          cfg_data
);

  // Configuration registers
  logic [7:0] max_errors;
  logic [7:0] idle_exit_limit;

  // Session state
  xmrx_pkg::phase_t               frame_phase, frame_phase_next;
  logic                           stx_packet, stx_packet_next;
  logic [7:0]                     expected_block, expected_block_next;
  logic                           got_first_packet, got_first_packet_next;
  logic [7:0]                     error_count, error_count_next;
  logic [7:0]                     timeout_count, timeout_count_next;
  logic [7:0]                     block_number_seen, block_number_seen_next;
  logic [7:0]                     block_check_seen, block_check_seen_next;
  logic [xmrx_pkg::INDEX_W-1:0]   payload_index, payload_index_next;
  logic [15:0]                    running_crc, running_crc_next;
  logic [7:0]                     crc_high_seen, crc_high_seen_next;
  xmrx_pkg::sess_t                session_state, session_state_next;

  // Result queue
  xmrx_pkg::out_t                 queue [xmrx_pkg::QUEUE_DEPTH];
  logic [xmrx_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [xmrx_pkg::QPTR_W:0]      count;

  // Decode
  logic        accept, pop;
  logic [7:0]  b;
  logic        is_start, is_byte, is_tick, mid_packet;
  logic [15:0] crc_upd;
  logic [xmrx_pkg::INDEX_W-1:0] index_inc, payload_size;
  logic        packet_end;
  logic        crc_bad, number_bad;
  logic [8:0]  block_sum;
  logic [7:0]  err_sat, to_sat;
  logic        err_abort, to_abort;
  logic        hdr_start, hdr_bad;
  logic [1:0]  nres;
  xmrx_pkg::out_t res0, res1;

  assign accept     = in_valid && in_ready;
  assign pop        = out_valid && out_ready;
  assign b          = in_data.rx_byte;
  assign is_start   = (in_data.opcode == xmrx_pkg::OP_START);
  assign is_byte    = (in_data.opcode == xmrx_pkg::OP_BYTE) &&
                      (session_state == xmrx_pkg::SS_RUN);
  assign is_tick    = (in_data.opcode == xmrx_pkg::OP_TICK) &&
                      (session_state == xmrx_pkg::SS_RUN);
  assign mid_packet = (frame_phase != xmrx_pkg::PH_HEADER);

  // Payload bookkeeping
  assign crc_upd      = xmrx_pkg::crc_byte(running_crc, b);
  assign index_inc    = payload_index + xmrx_pkg::INDEX_W'(1);
  assign payload_size = stx_packet ? xmrx_pkg::STX_PAYLOAD : xmrx_pkg::SOH_PAYLOAD;
  assign packet_end   = (index_inc >= payload_size);

  // Packet checks at the CRC low byte
  assign crc_bad    = ({crc_high_seen, b} != running_crc);
  assign block_sum  = {1'b0, block_number_seen} + {1'b0, block_check_seen};
  assign number_bad = (block_number_seen != expected_block) ||
                      (block_sum != {1'b0, xmrx_pkg::BLOCK_SUM});

  // Saturating counters and their limits
  assign err_sat   = (error_count == 8'hFF) ? error_count : error_count + 8'd1;
  assign err_abort = (err_sat >= max_errors);
  assign to_sat    = (timeout_count == 8'hFF) ? timeout_count : timeout_count + 8'd1;
  assign to_abort  = (to_sat >= idle_exit_limit);

  // Header byte classes
  assign hdr_start = (b == xmrx_pkg::CH_SOH) || (b == xmrx_pkg::CH_STX);
  assign hdr_bad   = !hdr_start && (b != xmrx_pkg::CH_EOT) && (b != xmrx_pkg::CH_CAN);

  // Next session state
  always_comb begin
    frame_phase_next       = frame_phase;
    stx_packet_next        = stx_packet;
    expected_block_next    = expected_block;
    got_first_packet_next  = got_first_packet;
    error_count_next       = error_count;
    timeout_count_next     = timeout_count;
    block_number_seen_next = block_number_seen;
    block_check_seen_next  = block_check_seen;
    payload_index_next     = payload_index;
    running_crc_next       = running_crc;
    crc_high_seen_next     = crc_high_seen;
    session_state_next     = session_state;
    if (is_start) begin
      frame_phase_next       = xmrx_pkg::PH_HEADER;
      stx_packet_next        = 1'b0;
      expected_block_next    = 8'd1;
      got_first_packet_next  = 1'b0;
      error_count_next       = '0;
      timeout_count_next     = '0;
      block_number_seen_next = '0;
      block_check_seen_next  = '0;
      payload_index_next     = '0;
      running_crc_next       = '0;
      crc_high_seen_next     = '0;
      session_state_next     = xmrx_pkg::SS_RUN;
    end else if (is_byte) begin
      unique case (frame_phase)
        xmrx_pkg::PH_HEADER: begin
          if (hdr_start) begin
            stx_packet_next  = (b == xmrx_pkg::CH_STX);
            frame_phase_next = xmrx_pkg::PH_BLOCK;
          end else if (b == xmrx_pkg::CH_EOT) begin
            got_first_packet_next = 1'b0;
            expected_block_next   = 8'd1;
            session_state_next    = xmrx_pkg::SS_DONE;
          end else if (b == xmrx_pkg::CH_CAN) begin
            session_state_next = xmrx_pkg::SS_ABORT;
          end else begin
            error_count_next = err_sat;
            if (err_abort) session_state_next = xmrx_pkg::SS_ABORT;
          end
        end
        xmrx_pkg::PH_BLOCK: begin
          block_number_seen_next = b;
          frame_phase_next       = xmrx_pkg::PH_CHECK;
        end
        xmrx_pkg::PH_CHECK: begin
          block_check_seen_next = b;
          payload_index_next    = '0;
          running_crc_next      = '0;
          frame_phase_next      = xmrx_pkg::PH_DATA;
        end
        xmrx_pkg::PH_DATA: begin
          running_crc_next   = crc_upd;
          payload_index_next = index_inc;
          if (packet_end) frame_phase_next = xmrx_pkg::PH_CRCHI;
        end
        xmrx_pkg::PH_CRCHI: begin
          crc_high_seen_next = b;
          frame_phase_next   = xmrx_pkg::PH_CRCLO;
        end
        default: begin
          frame_phase_next      = xmrx_pkg::PH_HEADER;
          got_first_packet_next = 1'b1;
          if (!crc_bad && !number_bad) begin
            expected_block_next = expected_block + 8'd1;
          end else begin
            error_count_next = err_sat;
            if (err_abort) session_state_next = xmrx_pkg::SS_ABORT;
          end
        end
      endcase
    end else if (is_tick) begin
      frame_phase_next = xmrx_pkg::PH_HEADER;
      if (got_first_packet) begin
        error_count_next = err_sat;
        if (err_abort) session_state_next = xmrx_pkg::SS_ABORT;
      end else if (to_abort) begin
        timeout_count_next = '0;
        session_state_next = xmrx_pkg::SS_ABORT;
      end else begin
        timeout_count_next = to_sat;
      end
    end
  end

  // Results of the current item
  always_comb begin
    logic       raise;
    logic       r_vv, r_ce, r_ne;
    raise = 1'b0;
    r_vv  = 1'b0;
    r_ce  = 1'b0;
    r_ne  = 1'b0;
    nres  = 2'd0;
    res0  = '0;
    res1  = '0;
    if (is_start) begin
      nres                = 2'd1;
      res0.tx_valid       = 1'b1;
      res0.tx_byte        = xmrx_pkg::CH_C;
      res0.verdict_valid  = mid_packet;
    end else if (is_byte) begin
      unique case (frame_phase)
        xmrx_pkg::PH_HEADER: begin
          if (b == xmrx_pkg::CH_EOT) begin
            nres          = 2'd1;
            res0.tx_valid = 1'b1;
            res0.tx_byte  = xmrx_pkg::CH_ACK;
          end else if (b == xmrx_pkg::CH_CAN) begin
            nres = 2'd1;
          end else if (hdr_bad) begin
            raise = 1'b1;
          end
        end
        xmrx_pkg::PH_DATA: begin
          nres            = 2'd1;
          res0.data_valid = 1'b1;
          res0.data_byte  = b;
        end
        xmrx_pkg::PH_CRCLO: begin
          if (!crc_bad && !number_bad) begin
            nres               = 2'd1;
            res0.tx_valid      = 1'b1;
            res0.tx_byte       = xmrx_pkg::CH_ACK;
            res0.verdict_valid = 1'b1;
            res0.packet_good   = 1'b1;
          end else begin
            raise = 1'b1;
            r_vv  = 1'b1;
            r_ce  = crc_bad;
            r_ne  = number_bad;
          end
        end
        default: nres = 2'd0;
      endcase
    end else if (is_tick) begin
      if (got_first_packet) begin
        raise = 1'b1;
        r_vv  = mid_packet;
      end else begin
        nres               = 2'd1;
        res0.tx_valid      = 1'b1;
        res0.tx_byte       = xmrx_pkg::CH_C;
        res0.verdict_valid = mid_packet;
      end
    end

    // Error reply: NAK below the limit, CAN CAN at or above it
    if (raise) begin
      res0.tx_valid      = 1'b1;
      res0.tx_byte       = err_abort ? xmrx_pkg::CH_CAN : xmrx_pkg::CH_NAK;
      res0.verdict_valid = r_vv;
      res0.crc_error     = r_ce;
      res0.number_error  = r_ne;
      res1.tx_valid      = 1'b1;
      res1.tx_byte       = xmrx_pkg::CH_CAN;
      nres               = err_abort ? 2'd2 : 2'd1;
    end

    res0.session_status = session_state_next;
    res1.session_status = session_state_next;
    res0.last           = (nres == 2'd1);
    res1.last           = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_errors      <= 8'd3;
      idle_exit_limit <= 8'd10;
    end else if (cfg_write) begin
      unique case (cfg_index)
        xmrx_pkg::CFG_MAX_ERRORS:      max_errors      <= cfg_data;
        xmrx_pkg::CFG_IDLE_EXIT_LIMIT: idle_exit_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance session state on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase       <= xmrx_pkg::PH_HEADER;
      stx_packet        <= 1'b0;
      expected_block    <= 8'd1;
      got_first_packet  <= 1'b0;
      error_count       <= '0;
      timeout_count     <= '0;
      block_number_seen <= '0;
      block_check_seen  <= '0;
      payload_index     <= '0;
      running_crc       <= '0;
      crc_high_seen     <= '0;
      session_state     <= xmrx_pkg::SS_RUN;
    end else if (accept) begin
      frame_phase       <= frame_phase_next;
      stx_packet        <= stx_packet_next;
      expected_block    <= expected_block_next;
      got_first_packet  <= got_first_packet_next;
      error_count       <= error_count_next;
      timeout_count     <= timeout_count_next;
      block_number_seen <= block_number_seen_next;
      block_check_seen  <= block_check_seen_next;
      payload_index     <= payload_index_next;
      running_crc       <= running_crc_next;
      crc_high_seen     <= crc_high_seen_next;
      session_state     <= session_state_next;
    end
  end

  // Result queue control: push up to two, pop one
  logic [1:0] push_n;
  assign push_n    = accept ? nres : 2'd0;
  assign in_ready  = (count < (xmrx_pkg::QPTR_W + 1)'(xmrx_pkg::QUEUE_DEPTH - 1));
  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + xmrx_pkg::QPTR_W'(push_n);
      rd_ptr <= rd_ptr + xmrx_pkg::QPTR_W'(pop);
      count  <= count + (xmrx_pkg::QPTR_W + 1)'(push_n)
                      - (xmrx_pkg::QPTR_W + 1)'(pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= res0;
    if (push_n == 2'd2) queue[wr_ptr + xmrx_pkg::QPTR_W'(1)] <= res1;
  end

endmodule

### sv/xmrx_checker.sv
// Port-level checks for the XMODEM-1K receiver, bound to the top level.
module xmrx_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input xmrx_pkg::in_t                     in_data,
  input logic                              out_valid,
  input logic                              out_ready,
  input xmrx_pkg::out_t                    out_data,
  input logic                              cfg_write,
  input logic [xmrx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [7:0]                        cfg_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Start always answers with a result on the next cycle
  a_start_reply: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.opcode == xmrx_pkg::OP_START |=> out_valid)
    else $error("start transfer gave no result");

  // A non-final result is the first CAN of an abort pair
  a_pair_can: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |->
      out_data.tx_byte == xmrx_pkg::CH_CAN &&
      out_data.session_status == xmrx_pkg::SS_ABORT)
    else $error("non-final result is not a CAN abort");

  // The second result of a pair follows right away
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=> out_valid && out_data.last)
    else $error("second result of a pair missing");

  // Payload results carry nothing else and the session is running
  a_data_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.data_valid |->
      !out_data.tx_valid && !out_data.verdict_valid &&
      out_data.session_status == xmrx_pkg::SS_RUN)
    else $error("payload result mixed with reply or verdict");

endmodule

bind xmodem_1k_crc_receiver_unit xmrx_port_checker u_xmrx_port_checker (.*);
